@@ rtl/ebcx_pkg.sv @@
package ebcx_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_MOVI = 4'd3,
		OP_BEQZ = 4'd4,
		OP_ANDI = 4'd5,
		OP_EOR  = 4'd6,
		OP_BR   = 4'd7,
		OP_SAL  = 4'd8,
		OP_SAR  = 4'd9,
		OP_LDR  = 4'd10,
		OP_STR  = 4'd11
	} opcode_t;

	localparam int FLAG_C = 0;
	localparam int FLAG_V = 1;
	localparam int FLAG_N = 2;
	localparam int FLAG_S = 3;
	localparam int FLAG_Z = 4;

	typedef struct packed {
		logic [3:0] op;
		logic [5:0] rd;
		logic [5:0] rs;
		logic [5:0] imm;
		logic       known;
	} decoded_t;

endpackage

@@ rtl/ebcx_ram.sv @@
module ebcx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ebcx_front.sv @@
module ebcx_front
	import ebcx_pkg::*;
#(
	parameter int REG_COUNT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [3:0] op,
	input  logic [5:0] dest_reg,
	input  logic [5:0] src_reg,
	input  logic [5:0] imm_bits,
	output logic       dq_valid,
	output decoded_t   dq_data,
	input  logic       dq_take
);

	localparam int RB = $clog2(REG_COUNT);

	decoded_t   ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	decoded_t   d;
	logic       acc;

	assign full = (cnt_q == 2'd2);
	assign acc = push && !full;
	assign dq_valid = (cnt_q != 2'd0);
	assign dq_data = ent_q[rp_q];

	always_comb begin
		d.op = op;
		d.rd = 6'(dest_reg[RB-1:0]);
		d.rs = 6'(src_reg[RB-1:0]);
		d.imm = imm_bits;
		d.known = (op <= OP_STR);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wp_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wp_q <= ~wp_q;
			if (dq_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(dq_take);
		end
	end

endmodule

@@ rtl/ebcx_back.sv @@
module ebcx_back
	import ebcx_pkg::*;
#(
	parameter int DATA_BYTES = 2048,
	parameter int REG_COUNT  = 64,
	parameter int CODE_WORDS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dq_valid,
	input  decoded_t          dq_data,
	output logic              dq_take,
	output logic              empty,
	input  logic              pop,
	output logic              reg_write,
	output logic [5:0]        written_reg,
	output logic signed [7:0] written_value,
	output logic              mem_write,
	output logic [4:0]        flags,
	output logic              branch_taken,
	output logic [9:0]        next_address,
	output logic              error
);

	localparam int RB = $clog2(REG_COUNT);
	localparam int DB = $clog2(DATA_BYTES);
	localparam int PB = $clog2(CODE_WORDS);

	typedef enum logic [1:0] {
		ST_FETCH = 2'b01,
		ST_EXEC  = 2'b10
	} state_t;

	state_t        state_q;
	decoded_t      cur_q;
	logic [PB-1:0] pc_q;
	logic [4:0]    flags_q;
	logic          out_v_q;
	logic [REG_COUNT-1:0]  rv_q;
	logic [63:0]   dv_q;

	logic [7:0] ra_raw, rb_raw, dm_raw, a_u, b_u, dm_u;
	logic       rf_we, dm_we;
	logic [7:0] rf_wd;

	// The read addresses follow the instruction being executed, so a held
	// instruction keeps its operands while the result waits.
	ebcx_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rfa (
		.clk(clk), .we(rf_we), .waddr(cur_q.rd[RB-1:0]), .wdata(rf_wd),
		.raddr(dq_take ? dq_data.rd[RB-1:0] : cur_q.rd[RB-1:0]), .rdata(ra_raw));
	ebcx_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rfb (
		.clk(clk), .we(rf_we), .waddr(cur_q.rd[RB-1:0]), .wdata(rf_wd),
		.raddr(dq_take ? dq_data.rs[RB-1:0] : cur_q.rs[RB-1:0]), .rdata(rb_raw));
	ebcx_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dm (
		.clk(clk), .we(dm_we), .waddr(DB'(cur_q.imm)), .wdata(a_u),
		.raddr(dq_take ? DB'(dq_data.imm) : DB'(cur_q.imm)), .rdata(dm_raw));

	// Entries never written since reset read as zero.
	assign a_u = rv_q[cur_q.rd[RB-1:0]] ? ra_raw : 8'd0;
	assign b_u = rv_q[cur_q.rs[RB-1:0]] ? rb_raw : 8'd0;
	assign dm_u = dv_q[cur_q.imm] ? dm_raw : 8'd0;

	logic exec_go;
	assign exec_go = (state_q == ST_EXEC) && (!out_v_q || pop);
	assign dq_take = (state_q == ST_FETCH) && dq_valid;

	logic signed [8:0] sa, sb, bb, sum9, dif9;
	logic signed [15:0] prod;
	logic [7:0] r;
	logic wr, taken, useb;
	logic [PB-1:0] nxt;
	logic [2:0] sh;
	logic [4:0] f;
	logic [15:0] cat;
	logic signed [PB:0] simm_pc;

	always_comb begin
		sa = {a_u[7], a_u};
		sb = {b_u[7], b_u};
		prod = 16'(sa[7:0] * sb[7:0]);
		r = 8'd0;
		wr = 1'b0;
		taken = 1'b0;
		useb = 1'b0;
		nxt = pc_q + PB'(1);
		sh = (cur_q.imm >= 6'd7) ? 3'd7 : cur_q.imm[2:0];
		cat = {a_u, b_u};
		simm_pc = (PB+1)'($signed(cur_q.imm));
		unique case (cur_q.op)
			OP_ADD: begin r = a_u + b_u; wr = 1'b1; useb = 1'b1; end
			OP_SUB: begin r = a_u - b_u; wr = 1'b1; useb = 1'b1; end
			OP_MUL: begin r = prod[7:0]; wr = 1'b1; useb = 1'b1; end
			OP_MOVI: begin r = 8'($signed(cur_q.imm)); wr = 1'b1; end
			OP_BEQZ: begin
				if (a_u == 8'd0) begin
					nxt = pc_q + PB'(1) + PB'(simm_pc);
					taken = 1'b1;
				end
			end
			OP_ANDI: begin r = a_u & {2'b00, cur_q.imm}; wr = 1'b1; end
			OP_EOR: begin r = a_u ^ b_u; wr = 1'b1; useb = 1'b1; end
			OP_BR: begin nxt = PB'(cat[15:6]) - PB'(1); taken = 1'b1; end
			OP_SAL: begin
				r = (cur_q.imm >= 6'd8) ? 8'd0 : (a_u << cur_q.imm[2:0]);
				wr = 1'b1;
			end
			OP_SAR: begin r = 8'($signed(a_u) >>> sh); wr = 1'b1; end
			OP_LDR: begin r = dm_u; wr = 1'b1; end
			default: ;
		endcase
		bb = useb ? sb : 9'sd0;
		sum9 = sa + bb;
		dif9 = sa - bb;
		f[FLAG_C] = (sum9 > 9'sd127) || (dif9 < -9'sd128);
		f[FLAG_V] = (!sa[8] && sa != 0 && !bb[8] && bb != 0 && r[7]) ||
			(sa[8] && bb[8] && !r[7] && r != 8'd0);
		f[FLAG_N] = r[7];
		f[FLAG_Z] = (r == 8'd0);
		f[FLAG_S] = f[FLAG_N] ^ f[FLAG_V];
	end

	assign rf_we = exec_go && wr;
	assign rf_wd = r;
	assign dm_we = exec_go && (cur_q.op == OP_STR);
	assign empty = !out_v_q;

	always_ff @(posedge clk) begin
		if (dq_take) cur_q <= dq_data;
		if (exec_go) begin
			reg_write <= wr;
			written_reg <= wr ? cur_q.rd : 6'd0;
			written_value <= wr ? r : 8'd0;
			mem_write <= (cur_q.op == OP_STR);
			flags <= wr ? f : flags_q;
			branch_taken <= taken;
			next_address <= 10'(nxt);
			error <= !cur_q.known;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			pc_q <= '0;
			flags_q <= '0;
			out_v_q <= 1'b0;
			rv_q <= '0;
			dv_q <= '0;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			if (dq_take) state_q <= ST_EXEC;
			if (exec_go) begin
				state_q <= ST_FETCH;
				out_v_q <= 1'b1;
				pc_q <= nxt;
				if (wr) begin
					flags_q <= f;
					rv_q[cur_q.rd[RB-1:0]] <= 1'b1;
				end
				if (dm_we) dv_q[cur_q.imm] <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/eight_bit_cpu_execute_unit.sv @@
// Execute unit of a small eight-bit processor.
// Input channel: push with full; a beat carries op, dest_reg, src_reg and
// imm_bits, one decoded instruction. A two-entry queue holds accepted beats.
// Result channel: empty with pop; each instruction yields one result beat with
// the register or memory write, flags, branch outcome, next pc and error.
// The back end handles each instruction in a fetch state, which reads the register
// file and data memory, then an execute state, which computes and writes back.
// It takes no new instruction until the last one has left that read then write loop.
// Reset clears the pc, flags and queues; per-entry valid bits make the
// register file and the first 64 data bytes read as zero until written.
// When pop stays low the finished result is held; the back end then waits and
// the input queue fills, after which full is raised.
module eight_bit_cpu_execute_unit
	import ebcx_pkg::*;
#(
	parameter int DATA_BYTES = 2048,
	parameter int REG_COUNT  = 64,
	parameter int CODE_WORDS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [3:0]        op,
	input  logic [5:0]        dest_reg,
	input  logic [5:0]        src_reg,
	input  logic [5:0]        imm_bits,
	output logic              empty,
	input  logic              pop,
	output logic              reg_write,
	output logic [5:0]        written_reg,
	output logic signed [7:0] written_value,
	output logic              mem_write,
	output logic [4:0]        flags,
	output logic              branch_taken,
	output logic [9:0]        next_address,
	output logic              error
);

	logic     dq_valid, dq_take;
	decoded_t dq_data;

	ebcx_front #(.REG_COUNT(REG_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.dest_reg(dest_reg), .src_reg(src_reg), .imm_bits(imm_bits),
		.dq_valid(dq_valid), .dq_data(dq_data), .dq_take(dq_take));

	ebcx_back #(.DATA_BYTES(DATA_BYTES), .REG_COUNT(REG_COUNT),
		.CODE_WORDS(CODE_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .dq_valid(dq_valid), .dq_data(dq_data),
		.dq_take(dq_take), .empty(empty), .pop(pop), .reg_write(reg_write),
		.written_reg(written_reg), .written_value(written_value),
		.mem_write(mem_write), .flags(flags), .branch_taken(branch_taken),
		.next_address(next_address), .error(error));

endmodule

@@ rtl/ebcx_checker.sv @@
module ebcx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       reg_write,
	input logic       mem_write,
	input logic       branch_taken,
	input logic       error,
	input logic [5:0] written_reg
);

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		empty == 1'b0 && !pop |=> !empty && $stable(written_reg))
		else $error("result changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(reg_write && mem_write))
		else $error("register and memory write together");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && error |-> !reg_write && !mem_write && !branch_taken)
		else $error("unknown opcode had an effect");

	a_no_reg: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !reg_write |-> written_reg == 6'd0)
		else $error("register number without write");

endmodule

bind eight_bit_cpu_execute_unit ebcx_checker u_chk (.*);
